[rtl/source_text_tokenizer_unit_assert.svh]
// Assertion macros shared by the tokenizer RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define STT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STT_ASSERT_IMPL(lbl, ante, cons, msg)
`define STT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/stt_pkg.sv]
`timescale 1ns / 1ps

package stt_pkg;

    // Width of the internal newline counter; the reported line saturates at 16 bits.
    localparam int LINE_WIDTH = 16;

    // Depth of the result queue at the output.
    localparam int QUEUE_DEPTH = 4;

    // Token type codes.
    localparam logic [2:0] TT_BINOP   = 3'd0;
    localparam logic [2:0] TT_PUNC    = 3'd1;
    localparam logic [2:0] TT_NUM     = 3'd2;
    localparam logic [2:0] TT_STR     = 3'd3;
    localparam logic [2:0] TT_BOOL    = 3'd4;
    localparam logic [2:0] TT_KEYWORD = 3'd5;
    localparam logic [2:0] TT_VAR     = 3'd6;
    localparam logic [2:0] TT_END     = 3'd7;

    // Binary operator codes.
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MOD  = 4'd4;
    localparam logic [3:0] OP_LE   = 4'd5;
    localparam logic [3:0] OP_GE   = 4'd6;
    localparam logic [3:0] OP_EQ   = 4'd7;
    localparam logic [3:0] OP_NE   = 4'd8;
    localparam logic [3:0] OP_LT   = 4'd9;
    localparam logic [3:0] OP_GT   = 4'd10;
    localparam logic [3:0] OP_ASN  = 4'd11;
    localparam logic [3:0] OP_AND  = 4'd12;
    localparam logic [3:0] OP_OR   = 4'd13;
    localparam logic [3:0] OP_NONE = 4'd15;

    // One result beat.
    typedef struct packed {
        logic [7:0]  lexeme;
        logic        byte_ok;
        logic [2:0]  ttype;
        logic [3:0]  code;
        logic        first;
        logic        last;
        logic [15:0] line;
    } stt_item_t;

    // Results caused by one source byte, in order from items[0].
    typedef struct packed {
        logic [1:0]           count;
        stt_item_t [2:0]      items;
    } stt_result_t;

endpackage

[rtl/source_text_tokenizer_unit.sv]
`timescale 1ns / 1ps
`include "source_text_tokenizer_unit_assert.svh"

// Channel   Handshake             Payload
// input     in_valid / in_stall   in_byte, input_last
// output    out_valid / out_stall lexeme_byte, byte_valid, token_type, token_code,
//                                 token_first, token_last, line_number
//
// One source byte is taken per cycle while each byte gives at most one beat and the output
// does not stall; a byte that gives k beats (up to three) holds the output port for k beats.
// Unless out_stall holds it, the output port, one beat per cycle from a four-entry result
// queue, sets the rate. Bytes pass the input register, then scan logic into the queue.
// Reset clears the input valid bit, the queue count and the scanner state at once.
// A stall on the output fills the queue, then in_stall rises while a byte waits.

module source_text_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        input_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  lexeme_byte,
    output logic        byte_valid,
    output logic [2:0]  token_type,
    output logic [3:0]  token_code,
    output logic        token_first,
    output logic        token_last,
    output logic [15:0] line_number
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               in_v_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;

    stt_item_t          q_reg [QUEUE_DEPTH];
    stt_item_t          q_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]   q_cnt_reg, q_cnt_next;
    logic [CNT_W-1:0]   cnt_mid;

    logic               pop;
    logic               room;
    logic               advance;
    stt_result_t        res;

    stt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .step_byte (in_byte_reg),
        .step_last (in_last_reg),
        .res       (res)
    );

    // A held byte moves on when the queue can take three more beats after this pop.
    assign pop     = (q_cnt_reg != '0) && !out_stall;
    assign room    = (q_cnt_reg <= CNT_W'(QUEUE_DEPTH - 3)) ||
                     ((q_cnt_reg == CNT_W'(QUEUE_DEPTH - 2)) && pop);
    assign advance = in_v_reg && room;
    assign in_stall = in_v_reg && !room;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_v_reg <= 1'b0;
        end else if (!in_stall) begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall) begin
            in_byte_reg <= in_byte;
            in_last_reg <= input_last;
        end
    end

    // Result queue: shift down on a pop, append the new beats behind the survivors.
    always_comb
    begin
        q_next = q_reg;
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
        end
        cnt_mid = q_cnt_reg - CNT_W'(pop);
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < res.count) begin
                    q_next[PTR_W'(cnt_mid) + PTR_W'(i)] = res.items[i];
                end
            end
            q_cnt_next = cnt_mid + CNT_W'(res.count);
        end else begin
            q_cnt_next = cnt_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            q_cnt_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // Output beat comes from the head of the queue.
    assign out_valid   = (q_cnt_reg != '0);
    assign lexeme_byte = q_reg[0].lexeme;
    assign byte_valid  = q_reg[0].byte_ok;
    assign token_type  = q_reg[0].ttype;
    assign token_code  = q_reg[0].code;
    assign token_first = q_reg[0].first;
    assign token_last  = q_reg[0].last;
    assign line_number = q_reg[0].line;

    // The queue never holds more beats than it has entries.
    `STT_ASSERT_IMPL(a_queue_bound, 1'b1, q_cnt_reg <= CNT_W'(QUEUE_DEPTH), "result queue overflow")

    // The input side is only held off while a byte waits in the input register.
    `STT_ASSERT_IMPL(a_stall_pending, in_stall, in_v_reg && !advance, "stall without a waiting byte")

    // A byte that moves on always leaves the queue room for its beats.
    `STT_ASSERT_NEXT(a_room_kept, advance, q_cnt_reg <= CNT_W'(QUEUE_DEPTH), "queue room check failed")

endmodule

[rtl/stt_lexer.sv]
`timescale 1ns / 1ps
`include "source_text_tokenizer_unit_assert.svh"

module stt_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          step_byte,
    input  logic                step_last,
    output stt_pkg::stt_result_t res
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_STR,
        MODE_WORD,
        MODE_OP,
        MODE_COMMENT
    } mode_t;

    typedef struct packed {
        logic      put;
        stt_item_t item;
    } close_t;

    // Character constants.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQ     = 8'h3D;

    // Reserved words: func, if, else, true, false (text left aligned).
    localparam logic [39:0] WORD_TEXT [5] = '{
        {"func", 8'h00}, {"if", 24'h000000}, {"else", 8'h00},
        {"true", 8'h00}, "false"
    };
    localparam logic [2:0] WORD_LEN [5] = '{3'd4, 3'd2, 3'd4, 3'd4, 3'd5};

    mode_t                   mode_reg, mode_next;
    logic [7:0]              held_byte_reg, held_byte_next;
    logic                    held_valid_reg, held_valid_next;
    logic                    held_first_reg, held_first_next;
    logic                    quote_kind_reg, quote_kind_next;
    logic [2:0]              word_length_reg, word_length_next;
    logic [4:0]              word_mask_reg, word_mask_next;
    logic [3:0]              op_code_reg, op_code_next;
    logic [LINE_WIDTH-1:0]   line_count_reg, line_count_next;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic [7:0] word_char(input int k, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = WORD_TEXT[k][39:32];
            3'd1:    ch = WORD_TEXT[k][31:24];
            3'd2:    ch = WORD_TEXT[k][23:16];
            3'd3:    ch = WORD_TEXT[k][15:8];
            3'd4:    ch = WORD_TEXT[k][7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Drops every reserved word that the new character rules out.
    function automatic logic [4:0] word_take(input logic [4:0] mask, input logic [2:0] len,
                                             input logic [7:0] c);
        logic [4:0] m;
        m = mask;
        for (int k = 0; k < 5; k++) begin
            if ((len >= WORD_LEN[k]) || (word_char(k, len) != c)) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    // Final type and code of an identifier: {type, code}.
    function automatic logic [6:0] word_final(input logic [4:0] mask, input logic [2:0] len);
        logic [6:0] tc;
        tc = {TT_VAR, 4'd0};
        for (int k = 0; k < 5; k++) begin
            if (mask[k] && (len == WORD_LEN[k])) begin
                if (k < 3) begin
                    tc = {TT_KEYWORD, 4'(k)};
                end else begin
                    tc = {TT_BOOL, (k == 3) ? 4'd1 : 4'd0};
                end
            end
        end
        return tc;
    endfunction

    function automatic logic [15:0] line_show(input logic [LINE_WIDTH-1:0] lc);
        logic [31:0] w;
        w = 32'(lc);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic stt_item_t make_item(input logic [7:0] b, input logic v,
                                            input logic [2:0] t, input logic [3:0] code,
                                            input logic f, input logic l,
                                            input logic [15:0] line);
        stt_item_t it;
        it.lexeme  = b;
        it.byte_ok = v;
        it.ttype   = t;
        it.code    = code;
        it.first   = f;
        it.last    = l;
        it.line    = line;
        return it;
    endfunction

    // Last beat of the token in progress, if it has one.
    function automatic close_t close_item(input mode_t m, input logic hv, input logic [7:0] hb,
                                          input logic hf, input logic [3:0] oc,
                                          input logic [4:0] wm, input logic [2:0] wl,
                                          input logic [15:0] line);
        close_t     ci;
        logic [6:0] tc;
        tc = word_final(wm, wl);
        ci.put  = 1'b0;
        ci.item = make_item(8'h00, 1'b0, TT_END, 4'd0, 1'b0, 1'b0, line);
        case (m)
            MODE_NUM:
            begin
                ci.put  = hv;
                ci.item = make_item(hb, 1'b1, TT_NUM, 4'd0, hf, 1'b1, line);
            end
            MODE_WORD:
            begin
                ci.put  = hv;
                ci.item = make_item(hb, 1'b1, tc[6:4], tc[3:0], hf, 1'b1, line);
            end
            MODE_STR:
            begin
                ci.put = 1'b1;
                if (hv) begin
                    ci.item = make_item(hb, 1'b1, TT_STR, 4'd0, hf, 1'b1, line);
                end else begin
                    ci.item = make_item(8'h00, 1'b0, TT_STR, 4'd0, 1'b1, 1'b1, line);
                end
            end
            MODE_OP:
            begin
                ci.put  = (oc != OP_NONE);
                ci.item = make_item(hb, 1'b1, TT_BINOP, oc, 1'b1, 1'b1, line);
            end
            default:
            begin
                ci.put = 1'b0;
            end
        endcase
        return ci;
    endfunction

    // One step of the scanner: state and current byte give the next state and the beats.
    always_comb
    begin
        mode_t           m;
        logic [7:0]      hb;
        logic            hv;
        logic            hf;
        logic            qk;
        logic [2:0]      wl;
        logic [4:0]      wm;
        logic [3:0]      oc;
        logic [LINE_WIDTH-1:0] lc;
        logic [1:0]      n;
        stt_item_t [2:0] items;
        logic            taken;
        logic            was_held;
        logic [15:0]     line_old;
        logic [15:0]     line_new;
        logic [3:0]      pair_code;
        logic [7:0]      c;
        close_t          ci;

        m        = mode_reg;
        hb       = held_byte_reg;
        hv       = held_valid_reg;
        hf       = held_first_reg;
        qk       = quote_kind_reg;
        wl       = word_length_reg;
        wm       = word_mask_reg;
        oc       = op_code_reg;
        lc       = line_count_reg;
        n        = 2'd0;
        items    = '0;
        taken    = 1'b0;
        was_held = 1'b0;
        c        = step_byte;
        ci       = '0;
        line_old = line_show(lc);
        pair_code = OP_NE;

        // Continue the token in progress; beats here carry the line before this byte.
        case (m)
            MODE_NUM:
            begin
                if (is_digit(c)) begin
                    items[n] = make_item(hb, 1'b1, TT_NUM, 4'd0, hf, 1'b0, line_old);
                    n = n + 2'd1;
                    hb = c;
                    hv = 1'b1;
                    hf = 1'b0;
                    taken = 1'b1;
                end else begin
                    ci = close_item(m, hv, hb, hf, oc, wm, wl, line_old);
                    if (ci.put) begin
                        items[n] = ci.item;
                        n = n + 2'd1;
                    end
                    m = MODE_IDLE;
                    hv = 1'b0;
                    hf = 1'b0;
                end
            end
            MODE_WORD:
            begin
                if (is_word(c)) begin
                    items[n] = make_item(hb, 1'b1, TT_VAR, 4'd0, hf, 1'b0, line_old);
                    n = n + 2'd1;
                    wm = word_take(wm, wl, c);
                    if (wl != 3'd7) begin
                        wl = wl + 3'd1;
                    end
                    hb = c;
                    hv = 1'b1;
                    hf = 1'b0;
                    taken = 1'b1;
                end else begin
                    ci = close_item(m, hv, hb, hf, oc, wm, wl, line_old);
                    if (ci.put) begin
                        items[n] = ci.item;
                        n = n + 2'd1;
                    end
                    m = MODE_IDLE;
                    hv = 1'b0;
                    hf = 1'b0;
                end
            end
            MODE_STR:
            begin
                if (c == (qk ? CH_DQUOTE : CH_SQUOTE)) begin
                    ci = close_item(m, hv, hb, hf, oc, wm, wl, line_old);
                    if (ci.put) begin
                        items[n] = ci.item;
                        n = n + 2'd1;
                    end
                    m = MODE_IDLE;
                    hv = 1'b0;
                    hf = 1'b0;
                end else begin
                    was_held = hv;
                    if (hv) begin
                        items[n] = make_item(hb, 1'b1, TT_STR, 4'd0, hf, 1'b0, line_old);
                        n = n + 2'd1;
                    end
                    hb = c;
                    hv = 1'b1;
                    hf = !was_held;
                end
                taken = 1'b1;
            end
            MODE_OP:
            begin
                if (c == CH_EQ) begin
                    case (hb)
                        "<":     pair_code = OP_LE;
                        ">":     pair_code = OP_GE;
                        "=":     pair_code = OP_EQ;
                        default: pair_code = OP_NE;
                    endcase
                    items[n] = make_item(hb, 1'b1, TT_BINOP, pair_code, 1'b1, 1'b0, line_old);
                    n = n + 2'd1;
                    items[n] = make_item(c, 1'b1, TT_BINOP, pair_code, 1'b0, 1'b1, line_old);
                    n = n + 2'd1;
                    m = MODE_IDLE;
                    hv = 1'b0;
                    taken = 1'b1;
                end else begin
                    ci = close_item(m, hv, hb, hf, oc, wm, wl, line_old);
                    if (ci.put) begin
                        items[n] = ci.item;
                        n = n + 2'd1;
                    end
                    m = MODE_IDLE;
                    hv = 1'b0;
                    hf = 1'b0;
                end
            end
            MODE_COMMENT:
            begin
                if (c == CH_NL) begin
                    m = MODE_IDLE;
                end
                taken = 1'b1;
            end
            default:
            begin
                m = MODE_IDLE;
            end
        endcase

        // Newline count, saturating.
        if ((c == CH_NL) && (lc != '1)) begin
            lc = lc + 1'b1;
        end
        line_new = line_show(lc);

        // Start a new token from a byte that no token took.
        if (!taken) begin
            case (c)
                "+", "-", "*", "/", "%", "&", "|":
                begin
                    case (c)
                        "+":     oc = OP_ADD;
                        "-":     oc = OP_SUB;
                        "*":     oc = OP_MUL;
                        "/":     oc = OP_DIV;
                        "%":     oc = OP_MOD;
                        "&":     oc = OP_AND;
                        default: oc = OP_OR;
                    endcase
                    items[n] = make_item(c, 1'b1, TT_BINOP, oc, 1'b1, 1'b1, line_new);
                    n = n + 2'd1;
                    oc = op_code_reg;
                end
                "<", ">", "=", "!":
                begin
                    case (c)
                        "<":     oc = OP_LT;
                        ">":     oc = OP_GT;
                        "=":     oc = OP_ASN;
                        default: oc = OP_NONE;
                    endcase
                    m = MODE_OP;
                    hb = c;
                    hv = 1'b1;
                    hf = 1'b1;
                end
                CH_SQUOTE, CH_DQUOTE:
                begin
                    m = MODE_STR;
                    qk = (c == CH_DQUOTE);
                    hv = 1'b0;
                end
                CH_HASH:
                begin
                    m = MODE_COMMENT;
                end
                "[", "]", "(", ")", "{", "}", ";":
                begin
                    case (c)
                        "[":     pair_code = 4'd0;
                        "]":     pair_code = 4'd1;
                        "(":     pair_code = 4'd2;
                        ")":     pair_code = 4'd3;
                        "{":     pair_code = 4'd4;
                        "}":     pair_code = 4'd5;
                        default: pair_code = 4'd6;
                    endcase
                    items[n] = make_item(c, 1'b1, TT_PUNC, pair_code, 1'b1, 1'b1, line_new);
                    n = n + 2'd1;
                end
                default:
                begin
                    if (is_digit(c)) begin
                        m = MODE_NUM;
                        hb = c;
                        hv = 1'b1;
                        hf = 1'b1;
                    end else if (is_alpha(c) || (c == "_")) begin
                        m = MODE_WORD;
                        wm = word_take(5'h1F, 3'd0, c);
                        wl = 3'd1;
                        hb = c;
                        hv = 1'b1;
                        hf = 1'b1;
                    end
                end
            endcase
        end

        // End of text: flush the open token, add END and return to the reset state.
        if (step_last) begin
            ci = close_item(m, hv, hb, hf, oc, wm, wl, line_new);
            if (ci.put && (n != 2'd3)) begin
                items[n] = ci.item;
                n = n + 2'd1;
            end
            if (n != 2'd3) begin
                items[n] = make_item(8'h00, 1'b0, TT_END, 4'd0, 1'b1, 1'b1, line_new);
                n = n + 2'd1;
            end
            m  = MODE_IDLE;
            hb = 8'h00;
            hv = 1'b0;
            hf = 1'b0;
            qk = 1'b0;
            wl = 3'd0;
            wm = 5'h1F;
            oc = 4'd0;
            lc = '0;
        end

        res.count = n;
        res.items = items;

        if (step_en) begin
            mode_next        = m;
            held_byte_next   = hb;
            held_valid_next  = hv;
            held_first_next  = hf;
            quote_kind_next  = qk;
            word_length_next = wl;
            word_mask_next   = wm;
            op_code_next     = oc;
            line_count_next  = lc;
        end else begin
            mode_next        = mode_reg;
            held_byte_next   = held_byte_reg;
            held_valid_next  = held_valid_reg;
            held_first_next  = held_first_reg;
            quote_kind_next  = quote_kind_reg;
            word_length_next = word_length_reg;
            word_mask_next   = word_mask_reg;
            op_code_next     = op_code_reg;
            line_count_next  = line_count_reg;
        end
    end

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= MODE_IDLE;
            held_byte_reg   <= 8'h00;
            held_valid_reg  <= 1'b0;
            held_first_reg  <= 1'b0;
            quote_kind_reg  <= 1'b0;
            word_length_reg <= 3'd0;
            word_mask_reg   <= 5'h1F;
            op_code_reg     <= 4'd0;
            line_count_reg  <= '0;
        end else begin
            mode_reg        <= mode_next;
            held_byte_reg   <= held_byte_next;
            held_valid_reg  <= held_valid_next;
            held_first_reg  <= held_first_next;
            quote_kind_reg  <= quote_kind_next;
            word_length_reg <= word_length_next;
            word_mask_reg   <= word_mask_next;
            op_code_reg     <= op_code_next;
            line_count_reg  <= line_count_next;
        end
    end

    // The final byte of a text always ends in an END beat.
    `STT_ASSERT_IMPL(a_end_beat, step_en && step_last, (res.count != 2'd0) && (res.items[res.count - 2'd1].ttype == TT_END), "final byte without END beat")

    // After the final byte the scanner is back in its reset state.
    `STT_ASSERT_NEXT(a_end_resets, step_en && step_last, (mode_reg == MODE_IDLE) && (line_count_reg == '0) && !held_valid_reg, "scanner not reset after end of text")

    // A held byte only exists while a multi-byte token is open.
    `STT_ASSERT_IMPL(a_held_in_token, held_valid_reg, (mode_reg == MODE_NUM) || (mode_reg == MODE_WORD) || (mode_reg == MODE_STR) || (mode_reg == MODE_OP), "held byte outside a token")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

import stt_pkg::*;

// Tracks the lexer state for every byte the block takes, keeps the lexeme beats
// that byte must produce, and compares each beat that leaves the block.
class token_scoreboard;
    localparam int W_FUNC = 0;
    localparam int W_IF = 1;
    localparam int W_ELSE = 2;
    localparam int W_TRUE = 3;
    localparam int W_FALSE = 4;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam int MAX_BEATS_PER_BYTE = 3;
    localparam int MAX_REPORTS = 200;

    typedef enum logic [2:0] {LX_IDLE, LX_NUM, LX_STR, LX_WORD, LX_OP, LX_COMMENT} lex_mode_t;

    string word_text[5] = '{"func", "if", "else", "true", "false"};
    string punc_text = "[](){};";

    lex_mode_t          mode;
    logic [7:0]         held_byte;
    bit                 held_valid;
    bit                 held_first;
    bit                 dquote;
    int unsigned        word_len_seen;
    logic [4:0]         word_mask;
    logic [3:0]         op_code;
    longint unsigned    newline_count;
    int                 beats_this_byte;

    stt_item_t expected_tokens[$];
    int errors;
    int beats_checked;
    int bytes_taken;
    int useful_items;
    int texts_done;

    function new();
        clear_state();
        errors = 0;
        beats_checked = 0;
        bytes_taken = 0;
        useful_items = 0;
        texts_done = 0;
    endfunction

    // Back to the state of a fresh text, line counter included.
    function void clear_state();
        mode = LX_IDLE;
        held_byte = 8'h00;
        held_valid = 0;
        held_first = 0;
        dquote = 0;
        word_len_seen = 0;
        word_mask = 5'h1F;
        op_code = OP_ADD;
        newline_count = 0;
    endfunction

    function void push_beat(logic [7:0] b, bit v, logic [2:0] t, logic [3:0] c, bit f, bit l);
        stt_item_t beat;
        if (beats_this_byte >= MAX_BEATS_PER_BYTE)
            return;
        beat.lexeme = b;
        beat.byte_ok = v;
        beat.ttype = t;
        beat.code = c;
        beat.first = f;
        beat.last = l;
        beat.line = (newline_count > 64'hFFFF) ? 16'hFFFF : newline_count[15:0];
        expected_tokens.push_back(beat);
        beats_this_byte++;
    endfunction

    function bit is_digit(logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function bit is_alpha(logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function bit is_word(logic [7:0] ch);
        return is_alpha(ch) || is_digit(ch) || ch == "_";
    endfunction

    // Drop every reserved word that no longer matches the identifier so far.
    function void word_take(logic [7:0] ch);
        for (int k = 0; k < 5; k++)
        begin
            if (word_len_seen >= word_text[k].len() || word_text[k][word_len_seen] != ch)
                word_mask[k] = 1'b0;
        end
        if (word_len_seen < 7)
            word_len_seen++;
    endfunction

    function void word_final(output logic [2:0] t, output logic [3:0] c);
        t = TT_VAR;
        c = 4'd0;
        for (int k = 0; k < 5; k++)
        begin
            if (word_mask[k] && word_len_seen == word_text[k].len())
            begin
                if (k == W_TRUE || k == W_FALSE)
                begin
                    t = TT_BOOL;
                    c = (k == W_TRUE) ? 4'd1 : 4'd0;
                end
                else
                begin
                    t = TT_KEYWORD;
                    c = 4'(k);
                end
            end
        end
    endfunction

    // The held byte leaves as the last beat of its token.
    function void close_token();
        logic [2:0] t;
        logic [3:0] c;
        case (mode)
            LX_NUM:
                if (held_valid)
                    push_beat(held_byte, 1, TT_NUM, 4'd0, held_first, 1);
            LX_WORD:
                if (held_valid)
                begin
                    word_final(t, c);
                    push_beat(held_byte, 1, t, c, held_first, 1);
                end
            LX_STR:
                if (held_valid)
                    push_beat(held_byte, 1, TT_STR, 4'd0, held_first, 1);
                else
                    push_beat(8'h00, 0, TT_STR, 4'd0, 1, 1);
            LX_OP:
                if (op_code != OP_NONE)
                    push_beat(held_byte, 1, TT_BINOP, op_code, 1, 1);
            default:
                ;
        endcase
        mode = LX_IDLE;
        held_valid = 0;
        held_first = 0;
    endfunction

    function void hold(logic [7:0] ch, bit first);
        held_byte = ch;
        held_valid = 1;
        held_first = first;
    endfunction

    // A byte seen outside any token either emits a one-byte token or opens one.
    function void start_token(logic [7:0] ch);
        case (ch)
            "+": push_beat(ch, 1, TT_BINOP, OP_ADD, 1, 1);
            "-": push_beat(ch, 1, TT_BINOP, OP_SUB, 1, 1);
            "*": push_beat(ch, 1, TT_BINOP, OP_MUL, 1, 1);
            "/": push_beat(ch, 1, TT_BINOP, OP_DIV, 1, 1);
            "%": push_beat(ch, 1, TT_BINOP, OP_MOD, 1, 1);
            "&": push_beat(ch, 1, TT_BINOP, OP_AND, 1, 1);
            "|": push_beat(ch, 1, TT_BINOP, OP_OR, 1, 1);
            "<":
            begin
                mode = LX_OP;
                op_code = OP_LT;
                hold(ch, 1);
            end
            ">":
            begin
                mode = LX_OP;
                op_code = OP_GT;
                hold(ch, 1);
            end
            "=":
            begin
                mode = LX_OP;
                op_code = OP_ASN;
                hold(ch, 1);
            end
            "!":
            begin
                mode = LX_OP;
                op_code = OP_NONE;
                hold(ch, 1);
            end
            CH_SQUOTE, CH_DQUOTE:
            begin
                mode = LX_STR;
                dquote = (ch == CH_DQUOTE);
                held_valid = 0;
            end
            "#":
                mode = LX_COMMENT;
            default:
            begin
                for (int k = 0; k < 7; k++)
                begin
                    if (punc_text[k] == ch)
                    begin
                        push_beat(ch, 1, TT_PUNC, 4'(k), 1, 1);
                        return;
                    end
                end
                if (is_digit(ch))
                begin
                    mode = LX_NUM;
                    hold(ch, 1);
                end
                else if (is_alpha(ch) || ch == "_")
                begin
                    mode = LX_WORD;
                    word_len_seen = 0;
                    word_mask = 5'h1F;
                    word_take(ch);
                    hold(ch, 1);
                end
            end
        endcase
    endfunction

    // Called for every source byte the block accepts.
    function void note_input(logic [7:0] ch, bit is_last);
        longint unsigned line_max = (64'd1 << LINE_WIDTH) - 1;
        bit taken = 0;
        bit first;
        logic [3:0] pair_code;
        beats_this_byte = 0;
        bytes_taken++;

        case (mode)
            LX_NUM:
                if (is_digit(ch))
                begin
                    push_beat(held_byte, 1, TT_NUM, 4'd0, held_first, 0);
                    hold(ch, 0);
                    taken = 1;
                end
                else
                    close_token();
            LX_WORD:
                if (is_word(ch))
                begin
                    push_beat(held_byte, 1, TT_VAR, 4'd0, held_first, 0);
                    word_take(ch);
                    hold(ch, 0);
                    taken = 1;
                end
                else
                    close_token();
            LX_STR:
            begin
                if (ch == (dquote ? CH_DQUOTE : CH_SQUOTE))
                    close_token();
                else
                begin
                    first = !held_valid;
                    if (held_valid)
                        push_beat(held_byte, 1, TT_STR, 4'd0, held_first, 0);
                    hold(ch, first);
                end
                taken = 1;
            end
            LX_OP:
                if (ch == "=")
                begin
                    // Two-byte operator: longest match wins.
                    if (held_byte == "<")
                        pair_code = OP_LE;
                    else if (held_byte == ">")
                        pair_code = OP_GE;
                    else if (held_byte == "=")
                        pair_code = OP_EQ;
                    else
                        pair_code = OP_NE;
                    push_beat(held_byte, 1, TT_BINOP, pair_code, 1, 0);
                    push_beat(ch, 1, TT_BINOP, pair_code, 0, 1);
                    mode = LX_IDLE;
                    held_valid = 0;
                    taken = 1;
                end
                else
                    close_token();
            LX_COMMENT:
            begin
                if (ch == CH_NL)
                    mode = LX_IDLE;
                taken = 1;
            end
            default:
                mode = LX_IDLE;
        endcase

        // Newlines count after beats owed to earlier bytes have been formed.
        if (ch == CH_NL && newline_count < line_max)
            newline_count++;

        if (!taken)
            start_token(ch);

        if (is_last)
        begin
            close_token();
            push_beat(8'h00, 0, TT_END, 4'd0, 1, 1);
            clear_state();
            texts_done++;
        end

        if (beats_this_byte > 0 || mode inside {LX_NUM, LX_STR, LX_WORD, LX_OP})
            useful_items++;
    endfunction

    function void cmp_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endfunction

    // Called for every beat the block delivers.
    function void check_result(stt_item_t got);
        stt_item_t want;
        if (expected_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: beat with no expected beat waiting, expected none, got %p",
                     $time, got);
            return;
        end
        want = expected_tokens.pop_front();
        beats_checked++;
        cmp_field("lexeme_byte", 16'(want.lexeme), 16'(got.lexeme));
        cmp_field("byte_valid", 16'(want.byte_ok), 16'(got.byte_ok));
        cmp_field("token_type", 16'(want.ttype), 16'(got.ttype));
        cmp_field("token_code", 16'(want.code), 16'(got.code));
        cmp_field("token_first", 16'(want.first), 16'(got.first));
        cmp_field("token_last", 16'(want.last), 16'(got.last));
        cmp_field("line_number", want.line, got.line);
    endfunction
endclass

module tb_top;
    localparam int TEXT_ITEMS = 420;
    localparam int PHASE_COUNT = 4;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        input_last;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  lexeme_byte;
    logic        byte_valid;
    logic [2:0]  token_type;
    logic [3:0]  token_code;
    logic        token_first;
    logic        token_last;
    logic [15:0] line_number;

    token_scoreboard sb;
    logic [7:0] src_text[$];
    stt_item_t seen_beat;
    bit in_fire;
    bit hold_req;
    int send_idle_pct;
    int stall_pct;

    string word_list[5] = '{"func", "if", "else", "true", "false"};
    string near_words[14] = '{"fun", "funcs", "i", "iff", "els", "elsee", "tru", "truex",
                              "fals", "falsey", "False", "IF", "_if", "if2"};
    string op_traps[8] = '{"<<", "=<", "!!", "===", "<>", "!==", "=!", ">>="};
    string single_ops = "+-*/%&|<>=";
    string pair_ops[4] = '{"<=", ">=", "==", "!="};
    string punc_chars = "[](){};";
    string id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string blank_chars = " \t\n\r";
    string broken_tails[7] = '{"'ab", "\"", "#xyz", "!", "<", "12", "els"};

    source_text_tokenizer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .input_last  (input_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lexeme_byte (lexeme_byte),
        .byte_valid  (byte_valid),
        .token_type  (token_type),
        .token_code  (token_code),
        .token_first (token_first),
        .token_last  (token_last),
        .line_number (line_number)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Both channels are sampled at the rising edge.
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
            sb.note_input(in_byte, input_last);
        if (rst_n && out_valid && !out_stall)
        begin
            seen_beat.lexeme = lexeme_byte;
            seen_beat.byte_ok = byte_valid;
            seen_beat.ttype = token_type;
            seen_beat.code = token_code;
            seen_beat.first = token_first;
            seen_beat.last = token_last;
            seen_beat.line = line_number;
            sb.check_result(seen_beat);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        int stall_run;
        bit hold_taken;
        stall_run = 0;
        hold_taken = 0;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                stall_run = HOLD_OFF_CYCLES;
            end
            if (stall_run > 0)
            begin
                out_stall <= 1'b1;
                stall_run--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void add_str(string s);
        foreach (s[i])
            src_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Appends one random token, mostly well formed, sometimes noise.
    function automatic void add_random_token();
        int n;
        logic [7:0] quote_ch;
        logic [7:0] other_ch;
        logic [7:0] ch;
        case ($urandom_range(0, 15))
            0, 14:
                add_str(word_list[$urandom_range(0, 4)]);
            1:
                add_str(near_words[$urandom_range(0, 13)]);
            2, 15:
            begin
                n = $urandom_range(1, 10);
                src_text.push_back(id_chars[$urandom_range(0, 52)]);
                for (int i = 1; i < n; i++)
                    src_text.push_back(pick_char(id_chars));
            end
            3:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    src_text.push_back(8'("0" + $urandom_range(0, 9)));
            end
            4:
            begin
                quote_ch = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                other_ch = (quote_ch == 8'h22) ? 8'h27 : 8'h22;
                src_text.push_back(quote_ch);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 9))
                        0: ch = 8'h0A;
                        1: ch = other_ch;
                        2: ch = 8'($urandom_range(128, 255));
                        default:
                        begin
                            ch = 8'($urandom_range(32, 126));
                            while (ch == quote_ch)
                                ch = 8'($urandom_range(32, 126));
                        end
                    endcase
                    src_text.push_back(ch);
                end
                src_text.push_back(quote_ch);
            end
            5:
                src_text.push_back(pick_char(single_ops));
            6:
                add_str(pair_ops[$urandom_range(0, 3)]);
            7:
                add_str("!x");
            8:
                src_text.push_back(pick_char(punc_chars));
            9:
            begin
                src_text.push_back("#");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                begin
                    ch = 8'($urandom_range(0, 255));
                    while (ch == 8'h0A)
                        ch = 8'($urandom_range(0, 255));
                    src_text.push_back(ch);
                end
                src_text.push_back(8'h0A);
            end
            10, 13:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    src_text.push_back(pick_char(blank_chars));
            end
            11:
                src_text.push_back(8'($urandom_range(0, 255)));
            default:
                add_str(op_traps[$urandom_range(0, 7)]);
        endcase
    endfunction

    function automatic void build_random_text();
        int ntok;
        src_text.delete();
        ntok = $urandom_range(1, 10);
        for (int i = 0; i < ntok; i++)
        begin
            add_random_token();
            if ($urandom_range(0, 1))
                src_text.push_back(" ");
        end
        // Some texts end in the middle of a token.
        if ($urandom_range(0, 99) < 15)
            add_str(broken_tails[$urandom_range(0, 6)]);
    endfunction

    // Presents one byte from a falling edge and returns at the falling edge after
    // it was taken, with valid still high.
    task automatic send_byte(logic [7:0] b, bit is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        input_last <= is_last;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic send_text();
        foreach (src_text[i])
            send_byte(src_text[i], i == src_text.size() - 1);
    endtask

    // Sender stays quiet until every expected beat has been delivered.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idle(int sender_pct, int receiver_pct);
        @(posedge clk);
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
        @(negedge clk);
    endtask

    initial
    begin
        int phase_end;
        in_valid = 0;
        in_byte = 8'h00;
        input_last = 0;
        hold_req = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 0;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: zero and high bytes, all two-byte operators, a dropped '!',
        // an empty string, a newline, and a number closed by the end of text.
        src_text.delete();
        src_text.push_back(8'h00);
        src_text.push_back(8'hFF);
        add_str("<=>===!=!a''\n9");
        send_text();
        // Unterminated string, comment, and held operator at the end of text.
        src_text.delete();
        add_str("\"ab");
        send_text();
        src_text.delete();
        add_str("#z");
        send_text();
        src_text.delete();
        add_str("<");
        send_text();
        drain();

        // Random texts, one idling mix per phase.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_idle(0, 0);
                1: set_idle(53, 0);
                2: set_idle(0, 53);
                default: set_idle(19, 19);
            endcase
            if (phase == 0)
            begin
                // Long output hold-off while bytes keep coming.
                @(posedge clk);
                hold_req = 1;
                @(negedge clk);
            end
            phase_end = sb.bytes_taken + TEXT_ITEMS / PHASE_COUNT;
            while (sb.bytes_taken < phase_end)
            begin
                build_random_text();
                send_text();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Run covered %0d texts, %0d source bytes (%0d in tokens), %0d beats checked,",
                 sb.texts_done, sb.bytes_taken, sb.useful_items, sb.beats_checked);
        $display("with four idle/stall mixes and a long output hold-off that backed up the input.");
        if (sb.errors == 0 && sb.expected_tokens.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[source_text_tokenizer_unit.f]
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_lexer.sv
rtl/source_text_tokenizer_unit.sv
sim/tb_top.sv
